// ===== design/bbalu_pkg.sv =====
package bbalu_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 5;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    CMD_DIV = 2'd0,
    CMD_MUL = 2'd1,
    CMD_ADD = 2'd2,
    CMD_RSV = 2'd3
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic div_step;
    logic emit_main;
    logic emit_carry;
  } bbalu_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic in_reserved;
    logic in_iterate;
    logic div_last;
    logic carry_pending;
    logic out_free;
  } bbalu_stat_t;

endpackage

// ===== design/bbalu_dp.sv =====
module bbalu_dp import bbalu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bbalu_ctl_t       ctl_i,
  output bbalu_stat_t      stat_o,
  input  logic [1:0]       cmd_i,
  input  logic [ByteW-1:0] operand_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             first_byte_i,
  input  logic             last_byte_i,
  input  logic             empty_number_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [ByteW-1:0] result_byte_o,
  output logic             byte_present_o,
  output logic [ByteW-1:0] remainder_o,
  output logic             end_of_number_o
);

  // latched item
  cmd_e               cmd_q;
  logic [ByteW-1:0]   op_q;
  logic [ByteW-1:0]   b_q;
  logic               first_q;
  logic               last_q;
  logic               empty_q;

  // running state
  logic [ByteW-1:0]   rv_q, rv_d;
  logic               nz_q, nz_d;

  // shift-subtract divider
  logic [ByteW-1:0]   r_q;
  logic [2*ByteW-1:0] dq_q;
  logic [CntW-1:0]    cnt_q;

  // output register
  logic               oval_q;
  logic [ByteW-1:0]   obyte_q;
  logic               opres_q;
  logic [ByteW-1:0]   orem_q;
  logic               oeon_q;

  logic [ByteW-1:0]   rv_eff;
  logic               in_rsv;
  logic [ByteW:0]     r_shift;
  logic               r_ge;
  logic [ByteW:0]     r_sub;
  logic [ByteW-1:0]   r_next;

  logic [2*ByteW-1:0] prod;
  logic [2*ByteW-1:0] mul_t;
  logic [ByteW-1:0]   add_c;
  logic [ByteW:0]     add_t;
  logic [ByteW-1:0]   quot;
  logic               nz_new;

  logic [ByteW-1:0]   m_byte;
  logic               m_pres;
  logic [ByteW-1:0]   m_rem;
  logic               m_eon;
  logic               m_two;

  assign in_rsv = (cmd_e'(cmd_i) == CMD_RSV);
  assign rv_eff = (first_byte_i || empty_number_i) ? '0 : rv_q;

  assign stat_o.in_reserved   = in_rsv;
  assign stat_o.in_iterate    = (cmd_e'(cmd_i) == CMD_DIV) && (operand_i != '0)
                                && !empty_number_i;
  assign stat_o.div_last      = (cnt_q == CntW'(1));
  assign stat_o.carry_pending = m_two;
  assign stat_o.out_free      = !oval_q || out_ready_i;

  // one quotient bit per step
  assign r_shift = {r_q, dq_q[2*ByteW-1]};
  assign r_ge    = (r_shift >= {1'b0, op_q});
  assign r_sub   = r_shift - {1'b0, op_q};
  assign r_next  = r_ge ? r_sub[ByteW-1:0] : r_shift[ByteW-1:0];

  assign prod  = {{ByteW{1'b0}}, b_q} * {{ByteW{1'b0}}, op_q};
  assign mul_t = prod + {{ByteW{1'b0}}, rv_q};
  assign add_c = first_q ? op_q : rv_q;
  assign add_t = {1'b0, add_c} + {1'b0, b_q};
  assign quot  = dq_q[ByteW-1:0];
  assign nz_new = nz_q || (quot != '0);

  // main result of the latched item and the state it leaves
  always_comb begin
    m_byte = '0;
    m_pres = 1'b0;
    m_rem  = '0;
    m_eon  = last_q;
    m_two  = 1'b0;
    rv_d   = rv_q;
    nz_d   = nz_q;
    if (empty_q) begin
      m_eon = 1'b1;
      case (cmd_q)
        CMD_DIV: m_rem = op_q;
        CMD_ADD: begin
          m_byte = op_q;
          m_pres = 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (cmd_q)
        CMD_DIV: begin
          if (op_q == '0) begin
            m_byte = b_q;
            m_pres = 1'b1;
          end else begin
            m_byte = quot;
            m_pres = nz_new;
            m_rem  = last_q ? r_q : '0;
            rv_d   = r_q;
            nz_d   = nz_new;
          end
        end
        CMD_MUL: begin
          if (op_q == '0) begin
            rv_d = '0;
          end else begin
            m_byte = mul_t[ByteW-1:0];
            m_pres = 1'b1;
            rv_d   = mul_t[2*ByteW-1:ByteW];
            m_two  = last_q && (rv_d != '0);
            m_eon  = last_q && !m_two;
          end
        end
        default: begin
          m_byte = add_t[ByteW-1:0];
          m_pres = 1'b1;
          rv_d   = {{(ByteW-1){1'b0}}, add_t[ByteW]};
          m_two  = last_q && add_t[ByteW];
          m_eon  = last_q && !m_two;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q   <= '0;
      nz_q   <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      if (ctl_i.load_in) begin
        rv_q <= rv_eff;
        if (first_byte_i || empty_number_i) nz_q <= 1'b0;
      end else if (ctl_i.emit_main) begin
        rv_q <= rv_d;
        nz_q <= nz_d;
      end
      if (ctl_i.emit_main || ctl_i.emit_carry) begin
        oval_q <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      cmd_q   <= cmd_e'(cmd_i);
      op_q    <= operand_i;
      b_q     <= data_byte_i;
      first_q <= first_byte_i;
      last_q  <= last_byte_i;
      empty_q <= empty_number_i;
      // a stored remainder at or above the divisor needs all sixteen bits
      if (rv_eff < operand_i) begin
        r_q   <= rv_eff;
        dq_q  <= {data_byte_i, {ByteW{1'b0}}};
        cnt_q <= CntW'(ByteW);
      end else begin
        r_q   <= '0;
        dq_q  <= {rv_eff, data_byte_i};
        cnt_q <= CntW'(2 * ByteW);
      end
    end else if (ctl_i.div_step) begin
      r_q   <= r_next;
      dq_q  <= {dq_q[2*ByteW-2:0], r_ge};
      cnt_q <= cnt_q - CntW'(1);
    end
    if (ctl_i.emit_main) begin
      obyte_q <= m_byte;
      opres_q <= m_pres;
      orem_q  <= m_rem;
      oeon_q  <= m_eon;
    end else if (ctl_i.emit_carry) begin
      obyte_q <= rv_q;
      opres_q <= 1'b1;
      orem_q  <= '0;
      oeon_q  <= 1'b1;
    end
  end

  assign out_valid_o     = oval_q;
  assign result_byte_o   = obyte_q;
  assign byte_present_o  = opres_q;
  assign remainder_o     = orem_q;
  assign end_of_number_o = oeon_q;

endmodule

// ===== design/bbalu_ctrl.sv =====
module bbalu_ctrl import bbalu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  bbalu_stat_t stat_i,
  output bbalu_ctl_t  ctl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT,
    S_CARRY
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    ctl_o.load_in    = 1'b0;
    ctl_o.div_step   = 1'b0;
    ctl_o.emit_main  = 1'b0;
    ctl_o.emit_carry = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        // a reserved command is taken and dropped
        if (in_valid_i && !stat_i.in_reserved) begin
          ctl_o.load_in = 1'b1;
          state_d = stat_i.in_iterate ? S_DIV : S_EMIT;
        end
      end
      S_DIV: begin
        ctl_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          ctl_o.emit_main = 1'b1;
          state_d = stat_i.carry_pending ? S_CARRY : S_IDLE;
        end
      end
      S_CARRY: begin
        if (stat_i.out_free) begin
          ctl_o.emit_carry = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== design/bytewise_bignum_small_operand_alu_core.sv =====
// channel  dir  fields (tdata / tuser / tlast)
// s_axis   in   operand, data_byte, first_byte / cmd, empty_number / last_byte
// m_axis   out  result_byte, remainder / byte_present / end_of_number
//
// multiply, add and divide by zero reach the result with no divide steps
// the shift-subtract divide runs over the byte, or over all sixteen bits when the
// stored remainder is not below the divisor, and retires one quotient bit per cycle
// a carry byte follows from its own state; one byte is in flight at a time
// the output register lets a new byte be taken while a result waits on m_axis_tready
// rst_ni clears the running remainder or carry and the output valid
module bytewise_bignum_small_operand_alu_core import bbalu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] operand, [15:8] data_byte, [16] first_byte
  input  logic [2:0]  s_axis_tuser,  // [1:0] cmd, [2] empty_number
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] result_byte, [15:8] remainder
  output logic [0:0]  m_axis_tuser,  // [0] byte_present
  output logic        m_axis_tlast
);

  bbalu_ctl_t  ctl;
  bbalu_stat_t stat;
  logic [ByteW-1:0] res_byte;
  logic [ByteW-1:0] rem_byte;
  logic             present;

  bbalu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  bbalu_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .stat_o          (stat),
    .cmd_i           (s_axis_tuser[1:0]),
    .operand_i       (s_axis_tdata[7:0]),
    .data_byte_i     (s_axis_tdata[15:8]),
    .first_byte_i    (s_axis_tdata[16]),
    .last_byte_i     (s_axis_tlast),
    .empty_number_i  (s_axis_tuser[2]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .result_byte_o   (res_byte),
    .byte_present_o  (present),
    .remainder_o     (rem_byte),
    .end_of_number_o (m_axis_tlast)
  );

  assign m_axis_tdata = {rem_byte, res_byte};
  assign m_axis_tuser = present;

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbalu_pkg::*;

  localparam int unsigned NumItems   = 400;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldAt     = 120;
  localparam int unsigned HoldCycles = 250;
  localparam int unsigned DirRows    = 25;

  // one byte of a number as offered on s_axis
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] operand;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       empty_number;
  } num_byte_t;

  // one result as seen on m_axis
  typedef struct packed {
    logic [7:0] result_byte;
    logic       byte_present;
    logic [7:0] remainder;
    logic       end_of_number;
  } alu_res_t;

  typedef struct packed {
    num_byte_t item;
    logic      typed;
    alu_res_t  want;
  } stim_row_t;

  // state starts at reset: each row with a typed result is an empty number or a first byte
  localparam stim_row_t DirTab [DirRows] = '{
    '{'{CMD_ADD, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b1}, 1'b1, '{8'hFF, 1'b1, 8'h00, 1'b1}},
    '{'{CMD_DIV, 8'h07, 8'h00, 1'b1, 1'b1, 1'b1}, 1'b1, '{8'h00, 1'b0, 8'h07, 1'b1}},
    '{'{CMD_MUL, 8'h55, 8'hAA, 1'b1, 1'b1, 1'b1}, 1'b1, '{8'h00, 1'b0, 8'h00, 1'b1}},
    '{'{CMD_RSV, 8'h12, 8'h34, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_DIV, 8'h00, 8'hA5, 1'b1, 1'b1, 1'b0}, 1'b1, '{8'hA5, 1'b1, 8'h00, 1'b1}},
    '{'{CMD_MUL, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0}, 1'b1, '{8'h00, 1'b0, 8'h00, 1'b1}},
    '{'{CMD_DIV, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0}, 1'b1, '{8'h01, 1'b1, 8'h00, 1'b1}},
    '{'{CMD_DIV, 8'h01, 8'h00, 1'b1, 1'b1, 1'b0}, 1'b1, '{8'h00, 1'b0, 8'h00, 1'b1}},
    '{'{CMD_ADD, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_MUL, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_MUL, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_DIV, 8'h03, 8'h01, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_DIV, 8'h03, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_DIV, 8'h03, 8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_DIV, 8'hC8, 8'hC7, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_DIV, 8'h03, 8'hFF, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_ADD, 8'h01, 8'hFF, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_ADD, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_ADD, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_MUL, 8'h02, 8'h80, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_ADD, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_DIV, 8'h00, 8'h5A, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_MUL, 8'h7F, 8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_DIV, 8'h10, 8'h00, 1'b1, 1'b1, 1'b1}, 1'b1, '{8'h00, 1'b0, 8'h10, 1'b1}},
    '{'{CMD_ADD, 8'h3C, 8'h99, 1'b0, 1'b0, 1'b1}, 1'b1, '{8'h3C, 1'b1, 8'h00, 1'b1}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [7:0] operand, [15:8] data_byte, [16] first_byte
  logic [2:0]  s_axis_tuser = '0;  // [1:0] cmd, [2] empty_number
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // [7:0] result_byte, [15:8] remainder
  logic [0:0]  m_axis_tuser;       // [0] byte_present
  logic        m_axis_tlast;

  // predictor state: running remainder or carry, and whether the quotient has started
  logic [7:0]  acc_q = '0;
  logic        quot_started = 1'b0;

  alu_res_t    results_due[$];
  int unsigned n_items = 0;
  int unsigned n_err = 0;
  int unsigned n_res = 0;
  int unsigned n_carry = 0;
  int unsigned cmd_cnt [4] = '{0, 0, 0, 0};
  int unsigned cycle_cnt = 0;
  logic        quiet;

  assign quiet = (n_items >= 250) && (n_items < 330);

  bytewise_bignum_small_operand_alu_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // works out the results of one byte and advances the predicted state
  function automatic int unsigned bignum_step(input num_byte_t it, output alu_res_t r0,
                                              output alu_res_t r1);
    logic [15:0] t;
    logic [7:0]  q;
    logic [7:0]  c;
    r0 = '0;
    r1 = '0;
    if (it.cmd == CMD_RSV) return 0;
    r0.end_of_number = 1'b1;
    if (it.empty_number) begin
      acc_q = '0;
      quot_started = 1'b0;
      case (it.cmd)
        CMD_DIV: r0.remainder = it.operand;
        CMD_ADD: begin
          r0.result_byte  = it.operand;
          r0.byte_present = 1'b1;
        end
        default: ;
      endcase
      return 1;
    end
    if (it.first_byte) begin
      acc_q = '0;
      quot_started = 1'b0;
    end
    r0.end_of_number = it.last_byte;
    if (it.cmd == CMD_DIV) begin
      // divide by zero passes the byte through and keeps the state
      if (it.operand == '0) begin
        r0.result_byte  = it.data_byte;
        r0.byte_present = 1'b1;
        return 1;
      end
      t = {acc_q, it.data_byte};
      q = 8'(t / 16'(it.operand));
      acc_q = 8'(t % 16'(it.operand));
      if (q != '0) quot_started = 1'b1;
      r0.result_byte  = q;
      r0.byte_present = quot_started;
      if (it.last_byte) r0.remainder = acc_q;
      return 1;
    end
    if (it.cmd == CMD_MUL && it.operand == '0) begin
      acc_q = '0;
      return 1;
    end
    c = (it.cmd == CMD_ADD && it.first_byte) ? it.operand : acc_q;
    if (it.cmd == CMD_MUL) t = {8'h00, c} + 16'(it.data_byte) * 16'(it.operand);
    else t = {8'h00, c} + {8'h00, it.data_byte};
    acc_q = t[15:8];
    r0.result_byte  = t[7:0];
    r0.byte_present = 1'b1;
    if (it.last_byte && acc_q != '0) begin
      r0.end_of_number = 1'b0;
      r1 = '{acc_q, 1'b1, 8'h00, 1'b1};
      return 2;
    end
    return 1;
  endfunction

  task automatic send_byte(input num_byte_t it, input logic typed, input alu_res_t want);
    alu_res_t    r0;
    alu_res_t    r1;
    int unsigned n;
    if (!quiet) begin
      while ($urandom_range(99) < 19) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, it.first_byte, it.data_byte, it.operand};
    s_axis_tuser  <= {it.empty_number, it.cmd};
    s_axis_tlast  <= it.last_byte;
    do @(posedge clk_i); while (!s_axis_tready);
    n = bignum_step(it, r0, r1);
    if (typed) begin
      results_due.push_back(want);
    end else begin
      if (n >= 1) results_due.push_back(r0);
      if (n == 2) results_due.push_back(r1);
    end
    if (n == 2) n_carry++;
    cmd_cnt[it.cmd]++;
    if (it.cmd != CMD_RSV) n_items++;
  endtask

  // mostly well-formed numbers with random content, now and then a broken head or tail
  task automatic send_random_number();
    num_byte_t it;
    int unsigned len;
    logic        no_head;
    logic        no_tail;
    it.cmd = ($urandom_range(99) < 4) ? CMD_RSV : cmd_e'($urandom_range(2));
    case ($urandom_range(9))
      0:       it.operand = 8'h00;
      1:       it.operand = 8'hFF;
      2:       it.operand = 8'h01;
      default: it.operand = 8'($urandom_range(255));
    endcase
    if ($urandom_range(9) == 0) begin
      it.data_byte    = 8'($urandom_range(255));
      it.first_byte   = 1'b1;
      it.last_byte    = 1'b1;
      it.empty_number = 1'b1;
      send_byte(it, 1'b0, '0);
      return;
    end
    len = ($urandom_range(7) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
    no_head = ($urandom_range(19) == 0);
    no_tail = ($urandom_range(19) == 0);
    it.empty_number = 1'b0;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(7))
        0, 1:    it.data_byte = 8'h00;
        2:       it.data_byte = 8'hFF;
        default: it.data_byte = 8'($urandom_range(255));
      endcase
      it.first_byte = (i == 0) && !no_head;
      it.last_byte  = (i == len - 1) && !no_tail;
      send_byte(it, 1'b0, '0);
    end
  endtask

  initial begin
    num_byte_t it;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int unsigned i = 0; i < DirRows; i++) begin
      send_byte(DirTab[i].item, DirTab[i].typed, DirTab[i].want);
    end
    while (n_items < NumItems) begin
      if ($urandom_range(99) < 15) begin
        // noise: every field drawn independently
        it.cmd          = cmd_e'($urandom_range(3));
        it.operand      = 8'($urandom_range(255));
        it.data_byte    = 8'($urandom_range(255));
        it.first_byte   = 1'($urandom_range(1));
        it.last_byte    = 1'($urandom_range(1));
        it.empty_number = ($urandom_range(7) == 0);
        send_byte(it, 1'b0, '0);
      end else begin
        send_random_number();
      end
    end
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("covered %0d divide, %0d multiply, %0d add and %0d reserved transfers",
             cmd_cnt[CMD_DIV], cmd_cnt[CMD_MUL], cmd_cnt[CMD_ADD], cmd_cnt[CMD_RSV]);
    $display("checked %0d results, %0d numbers ending in a carry byte", n_res, n_carry);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver: random back-pressure, one long hold-off to fill the block, none while quiet
  initial begin
    int unsigned hold_left;
    logic        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && n_items >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (quiet) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 19);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endfunction

  always @(posedge clk_i) begin
    alu_res_t got;
    alu_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tdata[15:8], m_axis_tlast};
      if (results_due.size() == 0) begin
        $error("result transfer with nothing expected: result_byte %0h", got.result_byte);
        n_err++;
      end else begin
        want = results_due.pop_front();
        check_field("result_byte", 32'(want.result_byte), 32'(got.result_byte));
        check_field("byte_present", 32'(want.byte_present), 32'(got.byte_present));
        check_field("remainder", 32'(want.remainder), 32'(got.remainder));
        check_field("end_of_number", 32'(want.end_of_number), 32'(got.end_of_number));
        n_res++;
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/bbalu_pkg.sv
design/bbalu_dp.sv
design/bbalu_ctrl.sv
design/bytewise_bignum_small_operand_alu_core.sv
tb/tb.sv
